FILE: rtl/assert_macros.svh
// Assertion helpers included by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/scara_pkg.sv
// ---------------------------------------------------------------------------
// scara_pkg
// Shared constants, CORDIC arctangent table and helper types.
// ---------------------------------------------------------------------------
package scara_pkg;

  localparam int AngW = 36;  // Q30 radians, range up to +-2^35
  localparam int DatW = 33;  // Q30 cos/sin with growth
  localparam int AtanEntries = 24;
  localparam int DefCordicStages = 16;

  localparam logic signed [AngW-1:0] Q30Pi = 36'sd3373259426;
  localparam logic signed [AngW-1:0] Q30HalfPi = 36'sd1686629713;
  localparam logic signed [AngW-1:0] Q30TwoPi = 36'sd6746518852;
  localparam logic signed [AngW-1:0] Q30ThreePi = 36'sd10119778278;
  localparam logic signed [AngW-1:0] Q30FourPi = 36'sd13493037704;
  localparam logic signed [AngW-1:0] Q30FivePi = 36'sd16866297130;
  localparam logic signed [AngW-1:0] Q30SixPi = 36'sd20239556556;
  localparam logic signed [DatW-1:0] Q30Gain = 33'sd652032874;

  localparam logic [1:0] RegUpper = 2'd0;
  localparam logic [1:0] RegLower = 2'd1;
  localparam logic [1:0] RegBase = 2'd2;
  localparam logic [1:0] RegGrip = 2'd3;

  function automatic logic signed [AngW-1:0] atan_q30(input int i);
    logic [31:0] v;
    begin
      case (i)
        0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
        3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
        6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
        9: v = 32'h001FFFFD;  10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
        12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
        15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
        18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
        21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
        default: v = 32'h0;
      endcase
      atan_q30 = $signed({4'b0, v});
    end
  endfunction

  typedef struct packed {
    logic signed [DatW-1:0] c;
    logic signed [DatW-1:0] s;
  } sincos_t;

endpackage

FILE: rtl/scara_forward_kinematics_unit.sv
// ---------------------------------------------------------------------------
// scara_forward_kinematics_unit
// Two-link SCARA forward kinematics: joint state in, tool pose out.
// ---------------------------------------------------------------------------
// Fully pipelined: one item per cycle unless stalled. Register stages, in
// order: input register, range reduction, one stage per CORDIC iteration
// (CORDIC_STAGES, capped at 24), sign fix, multiply, sum/round, saturate.
// A whole-pipe stall is applied when the output register is full and not
// taken.
module scara_forward_kinematics_unit
  import scara_pkg::*;
#(
  parameter int CORDIC_STAGES = DefCordicStages
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // shoulder_angle, elbow_angle, vertical_travel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // tool_x, tool_y, tool_z, quat_z, quat_w
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data
);

`include "assert_macros.svh"

  localparam int NStg = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
  localparam int Lat = NStg + 6;  // stages ending in the output register

  logic [14:0] upper_link_length, lower_link_length, base_height, gripper_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_link_length <= 15'd2458;
      lower_link_length <= 15'd2458;
      base_height <= 15'd2458;
      gripper_height <= 15'd819;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegUpper: upper_link_length <= cfg_data;
        RegLower: lower_link_length <= cfg_data;
        RegBase:  base_height <= cfg_data;
        RegGrip:  gripper_height <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [Lat-1:0] vld;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], s_axis_tvalid};
  end

  // stage 0: input register
  logic signed [15:0] a_r, d_r;
  logic signed [16:0] yaw_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= $signed(s_axis_tdata[15:0]);
      yaw_r <= 17'($signed(s_axis_tdata[15:0])) + 17'($signed(s_axis_tdata[31:16]));
      d_r <= $signed(s_axis_tdata[47:32]);
    end
  end

  sincos_t sc_a, sc_y, sc_h;
  scara_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cor_a (
    .clk(clk), .en(en), .angle({{2{a_r[15]}}, a_r, 18'd0}), .result(sc_a));
  scara_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cor_y (
    .clk(clk), .en(en), .angle({yaw_r[16], yaw_r, 18'd0}), .result(sc_y));
  scara_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cor_h (
    .clk(clk), .en(en), .angle({{2{yaw_r[16]}}, yaw_r, 17'd0}), .result(sc_h));

  // z path delayed to match
  logic signed [17:0] zd [NStg+4];
  always_ff @(posedge clk) begin
    if (en) begin
      zd[0] <= 18'(d_r) + 18'($signed({1'b0, base_height}))
             - 18'($signed({1'b0, gripper_height, 1'b0}));
      for (int i = 1; i < NStg + 4; i++) zd[i] <= zd[i-1];
    end
  end

  // multiply stage
  logic signed [48:0] m1c, m2c, m1s, m2s;
  logic signed [DatW-1:0] ch_r, sh_r;
  always_ff @(posedge clk) begin
    if (en) begin
      m1c <= $signed({1'b0, upper_link_length}) * sc_a.c;
      m2c <= $signed({1'b0, lower_link_length}) * sc_y.c;
      m1s <= $signed({1'b0, upper_link_length}) * sc_a.s;
      m2s <= $signed({1'b0, lower_link_length}) * sc_y.s;
      ch_r <= sc_h.c;
      sh_r <= sc_h.s;
    end
  end

  // sum and round
  logic signed [19:0] px, py;
  logic signed [17:0] qz_r, qw_r;
  logic signed [49:0] sx, sy;
  logic signed [DatW:0] rz, rw;
  always_comb begin
    sx = 50'(m1c) + 50'(m2c) + 50'sd536870912;
    sy = 50'(m1s) + 50'(m2s) + 50'sd536870912;
    rz = (DatW+1)'(sh_r) + (DatW+1)'(32768);
    rw = (DatW+1)'(ch_r) + (DatW+1)'(32768);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      px <= sx[49:30];
      py <= sy[49:30];
      qz_r <= rz[DatW:16];
      qw_r <= rw[DatW:16];
    end
  end

  function automatic logic [17:0] sat18(input logic signed [19:0] v);
    if (v > 20'sd131071) sat18 = 18'h1FFFF;
    else if (v < -20'sd131072) sat18 = 18'h20000;
    else sat18 = v[17:0];
  endfunction

  function automatic logic [15:0] satq(input logic signed [17:0] v);
    if (v > 18'sd16384) satq = 16'd16384;
    else if (v < -18'sd16384) satq = 16'hC000;
    else satq = v[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {2'b00, satq(qw_r), satq(qz_r), zd[NStg+3], sat18(py), sat18(px)};
    end
  end

  `ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output item changed while stalled")
  `ASSERT_IMPL(a_ready, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken during output stall")
  `ASSERT_NEXT(a_adv, s_axis_tvalid && s_axis_tready, vld[0], "accepted item lost its valid bit")

endmodule

FILE: rtl/scara_cordic.sv
// ---------------------------------------------------------------------------
// scara_cordic
// Pipelined rotation-mode CORDIC: Q30 angle in, Q30 cos/sin out. One
// register stage for range reduction, one per iteration, one for the sign.
// Advances only when en is high.
// ---------------------------------------------------------------------------
module scara_cordic
  import scara_pkg::*;
#(
  parameter int CORDIC_STAGES = DefCordicStages
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [AngW-1:0] angle,
  output sincos_t                result
);

  localparam int NStg = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;

  logic signed [AngW-1:0] t [NStg+1];
  logic signed [DatW-1:0] x [NStg+1];
  logic signed [DatW-1:0] y [NStg+1];
  logic                   flip [NStg+1];
  logic signed [AngW-1:0] red1, red2;
  logic                   flip_next;

  // input range within +-7 pi: wrap count picked by compare, up to three
  always_comb begin
    if (angle > Q30FivePi) red1 = angle - Q30SixPi;
    else if (angle > Q30ThreePi) red1 = angle - Q30FourPi;
    else if (angle > Q30Pi) red1 = angle - Q30TwoPi;
    else if (angle < -Q30FivePi) red1 = angle + Q30SixPi;
    else if (angle < -Q30ThreePi) red1 = angle + Q30FourPi;
    else if (angle < -Q30Pi) red1 = angle + Q30TwoPi;
    else red1 = angle;
    flip_next = 1'b0;
    red2 = red1;
    if (red1 > Q30HalfPi) begin
      red2 = red1 - Q30Pi;
      flip_next = 1'b1;
    end else if (red1 < -Q30HalfPi) begin
      red2 = red1 + Q30Pi;
      flip_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t[0] <= red2;
      x[0] <= Q30Gain;
      y[0] <= '0;
      flip[0] <= flip_next;
    end
  end

  for (genvar i = 0; i < NStg; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        flip[i+1] <= flip[i];
        if (t[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          t[i+1] <= t[i] - atan_q30(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          t[i+1] <= t[i] + atan_q30(i);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.c <= flip[NStg] ? -x[NStg] : x[NStg];
      result.s <= flip[NStg] ? -y[NStg] : y[NStg];
    end
  end

endmodule
